### hdl/dq_pkg.sv
// Package for the double-ended queue: request and error codes,
// default sizes and the step descriptor passed from pointer logic to control.
// No dependencies.
`default_nettype none

package dq_pkg;

  // Default number of ring entries and payload width
  localparam int unsigned DepthDef = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ReqW     = 3;
  localparam int unsigned ErrW     = 2;

  // Request codes; unused codes behave as a query
  typedef enum logic [ReqW-1:0] {
    REQ_QUERY      = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_PUSH_BACK  = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4
  } req_e;

  // Error codes reported with each result
  typedef enum logic [ErrW-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  // What one request does to the store and to the end-value caches
  typedef struct packed {
    logic wr;        // write the pushed value
    logic rd;        // fetch a new end value from the store
    logic rd_back;   // fetched value is the new back (else the new front)
    logic set_front; // pushed value becomes the front
    logic set_back;  // pushed value becomes the back
    logic err_empty; // pop on empty
    logic err_full;  // push on full
  } dq_op_t;

endpackage

`default_nettype wire

### hdl/dq_req_if.sv
// Request channel of the double-ended queue: valid/ready plus the request beat.
// Depends on dq_pkg for field widths.
`default_nettype none

interface dq_req_if
  import dq_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [ReqW-1:0]         req_type;
  logic signed [DataW-1:0] data_value;

  modport source (output valid, output req_type, output data_value, input ready);
  modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

`default_nettype wire

### hdl/dq_rsp_if.sv
// Result channel of the double-ended queue: valid/ready plus the result beat.
// Depends on dq_pkg for field widths; the count width follows the ring depth.
`default_nettype none

interface dq_rsp_if
  import dq_pkg::*;
#(
  parameter int unsigned CntW = 5
);
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] front_value;
  logic signed [DataW-1:0] back_value;
  logic [CntW-1:0]         entry_count;
  logic                    is_empty;
  logic [ErrW-1:0]         error_code;

  modport source (output valid, output front_value, output back_value,
                  output entry_count, output is_empty, output error_code,
                  input ready);
  modport sink   (input valid, input front_value, input back_value,
                  input entry_count, input is_empty, input error_code,
                  output ready);
endinterface

`default_nettype wire

### hdl/dq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/dq_ptr.sv
// Ring pointers and entry count of the double-ended queue; decodes each
// accepted request into a store access. Depends on dq_pkg.
`default_nettype none

module dq_ptr
  import dq_pkg::*;
#(
  parameter int unsigned Depth = DepthDef,
  localparam int unsigned IdxW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [ReqW-1:0] req_type_i,
  output dq_op_t               op_o,
  output logic [IdxW-1:0]      wr_idx_o,
  output logic [IdxW-1:0]      rd_idx_o,
  output logic [CntW-1:0]      count_o
);

  logic [IdxW-1:0] front_q, front_d;
  logic [IdxW-1:0] back_q, back_d;
  logic [CntW-1:0] count_q, count_d;

  logic [IdxW-1:0] front_inc, front_dec, back_inc, back_dec;
  logic            is_full, is_empty;
  dq_op_t          op;

  // Ring neighbours, wrapping at Depth
  assign front_inc = (front_q == IdxW'(Depth - 1)) ? '0 : front_q + 1'b1;
  assign back_inc  = (back_q  == IdxW'(Depth - 1)) ? '0 : back_q + 1'b1;
  assign front_dec = (front_q == '0) ? IdxW'(Depth - 1) : front_q - 1'b1;
  assign back_dec  = (back_q  == '0) ? IdxW'(Depth - 1) : back_q - 1'b1;

  assign is_full  = (count_q == CntW'(Depth));
  assign is_empty = (count_q == '0);

  // Request decode and next pointers
  always_comb begin
    op       = '0;
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    wr_idx_o = front_q;
    rd_idx_o = front_inc;
    case (req_type_i)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (is_full) begin
          op.err_full = 1'b1;
        end else if (is_empty) begin
          // first entry sits at the front index and is both ends
          op.wr        = 1'b1;
          op.set_front = 1'b1;
          op.set_back  = 1'b1;
          back_d       = front_q;
          count_d      = CntW'(1);
        end else if (req_type_i == REQ_PUSH_FRONT) begin
          op.wr        = 1'b1;
          op.set_front = 1'b1;
          front_d      = front_dec;
          wr_idx_o     = front_dec;
          count_d      = count_q + 1'b1;
        end else begin
          op.wr       = 1'b1;
          op.set_back = 1'b1;
          back_d      = back_inc;
          wr_idx_o    = back_inc;
          count_d     = count_q + 1'b1;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (is_empty) begin
          op.err_empty = 1'b1;
        end else begin
          count_d = count_q - 1'b1;
          if (count_q == CntW'(1)) begin
            // last entry gone: both ends meet again
            if (req_type_i == REQ_POP_FRONT) begin
              front_d = front_inc;
              back_d  = front_inc;
            end else begin
              back_d = front_q;
            end
          end else if (req_type_i == REQ_POP_FRONT) begin
            op.rd    = 1'b1;
            front_d  = front_inc;
            rd_idx_o = front_inc;
          end else begin
            op.rd      = 1'b1;
            op.rd_back = 1'b1;
            back_d     = back_dec;
            rd_idx_o   = back_dec;
          end
        end
      end
      default: begin
        // query and unused codes change nothing
      end
    endcase
  end

  // Pointer registers move only on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  assign op_o    = op;
  assign count_o = count_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count beyond ring depth");

  a_empty_ends_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (front_q == back_q))
    else $error("empty ring with separated ends");

  a_error_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (op.err_full || op.err_empty)) |=>
      ($stable(count_q) && $stable(front_q) && $stable(back_q)))
    else $error("rejected request changed the pointers");
`endif

endmodule

`default_nettype wire

### hdl/double_ended_queue.sv
// Top level of the double-ended queue: request sequencer, end-value caches,
// result register and the entry store. Depends on dq_pkg, dq_req_if,
// dq_rsp_if, dq_ram and dq_ptr.
//
// Bounded deque of signed 32-bit values in a ring of DEPTH entries held in a
// synchronous RAM. One request is worked on at a time: a push, a query, a
// rejected request or a pop that empties the deque goes from its accepted
// beat to the done step; a pop that leaves entries passes a read step
// first, as the new end value comes from the RAM's registered read port.
// The done step loads the result register once the previous result has
// been taken. The next request is taken as soon as the result is in the
// result register, even while that result still waits to be taken. The
// front and back values are kept in registers beside the RAM, so each
// request needs at most one RAM access. The RAM is not cleared after
// reset; it is only ever read at entries that hold a value.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  localparam int unsigned IdxW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  dq_op_t          op;
  logic [IdxW-1:0] wr_idx, rd_idx;
  logic [CntW-1:0] count;
  logic            accept;
  logic            load_out;
  logic [DataW-1:0] rd_data;

  logic             rd_back_q;
  err_e             err_q;
  logic [DataW-1:0] front_q, back_q;

  logic             out_valid_q;
  logic [DataW-1:0] out_front_q, out_back_q;
  logic [CntW-1:0]  out_count_q;
  logic             out_empty_q;
  err_e             out_err_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign load_out    = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  dq_ptr #(
    .Depth (DEPTH)
  ) u_ptr (
    .clk_i,
    .rst_ni,
    .accept_i   (accept),
    .req_type_i (req_i.req_type),
    .op_o       (op),
    .wr_idx_o   (wr_idx),
    .rd_idx_o   (rd_idx),
    .count_o    (count)
  );

  dq_ram #(
    .Width (DataW),
    .Depth (DEPTH)
  ) u_store (
    .clk_i,
    .wr_en_i   (accept && op.wr),
    .wr_addr_i (wr_idx),
    .wr_data_i (req_i.data_value),
    .rd_en_i   (accept && op.rd),
    .rd_addr_i (rd_idx),
    .rd_data_o (rd_data)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = op.rd ? S_READ : S_DONE;
      S_READ: state_d = S_DONE;
      S_DONE: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // End-value caches and per-request error
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_back_q <= op.rd_back;
      if (op.set_front) front_q <= req_i.data_value;
      if (op.set_back)  back_q  <= req_i.data_value;
      if (op.err_full) begin
        err_q <= ERR_FULL;
      end else if (op.err_empty) begin
        err_q <= ERR_EMPTY;
      end else begin
        err_q <= ERR_OK;
      end
    end
    if (state_q == S_READ) begin
      if (rd_back_q) begin
        back_q <= rd_data;
      end else begin
        front_q <= rd_data;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_front_q <= (count == '0) ? '0 : front_q;
      out_back_q  <= (count == '0) ? '0 : back_q;
      out_count_q <= count;
      out_empty_q <= (count == '0);
      out_err_q   <= err_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.front_value = out_front_q;
  assign rsp_o.back_value  = out_back_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.is_empty    = out_empty_q;
  assign rsp_o.error_code  = out_err_q;

`ifndef SYNTH
  a_read_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op.rd) |=> (state_q == S_READ))
    else $error("store read issued without a read cycle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared outside the done step");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=> (out_valid_q && $stable(out_count_q)))
    else $error("waiting result was dropped or changed");
`endif

endmodule

`default_nettype wire
